// File: rtl/core/gcm_pkg.sv
package gcm_pkg;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_AAD    = 2'd1;
	localparam logic [1:0] MODE_TEXT   = 2'd2;
	localparam logic [1:0] MODE_FINISH = 2'd3;

	localparam int BLK_BYTES = 16;
	localparam int RK_DEPTH  = 30;

	localparam logic [2:0] REG_KEY0    = 3'd0;
	localparam logic [2:0] REG_KEY1    = 3'd1;
	localparam logic [2:0] REG_KEY2    = 3'd2;
	localparam logic [2:0] REG_KEY3    = 3'd3;
	localparam logic [2:0] REG_KEY_LEN = 3'd4;
	localparam logic [2:0] REG_DECRYPT = 3'd5;

	typedef logic [127:0] block_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd1: r = 8'h01;
			4'd2: r = 8'h02;
			4'd3: r = 8'h04;
			4'd4: r = 8'h08;
			4'd5: r = 8'h10;
			4'd6: r = 8'h20;
			4'd7: r = 8'h40;
			4'd8: r = 8'h80;
			4'd9: r = 8'h1b;
			4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] t);
		return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t byte_mask(input logic [4:0] n);
		block_t m;
		m = '0;
		for (int j = 0; j < BLK_BYTES; j++) begin
			if (5'(j) < n)
				m[127 - 8 * j -: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic block_t aes_round(input block_t s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		block_t r;
		for (int j = 0; j < 16; j++)
			b[j] = SBOX[s[127 - 8 * j -: 8]];
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				t[c * 4 + j] = b[((c + j) % 4) * 4 + j];
		for (int c = 0; c < 4; c++) begin
			a0 = t[c * 4];
			a1 = t[c * 4 + 1];
			a2 = t[c * 4 + 2];
			a3 = t[c * 4 + 3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (!last) begin
				t[c * 4]     = a0 ^ al ^ xtime(a0 ^ a1);
				t[c * 4 + 1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[c * 4 + 2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[c * 4 + 3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int j = 0; j < 16; j++)
			r[127 - 8 * j -: 8] = t[j];
		return r;
	endfunction

endpackage

// File: rtl/core/gcm_if.sv
interface gcm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] in_hi;
	logic [63:0] in_lo;
	logic [4:0]  in_bytes;
	modport source (output valid, mode, in_hi, in_lo, in_bytes, input ready);
	modport sink (input valid, mode, in_hi, in_lo, in_bytes, output ready);
endinterface

interface gcm_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_hi;
	logic [63:0] out_lo;
	logic [4:0]  out_bytes;
	logic        is_tag;
	modport source (output valid, out_hi, out_lo, out_bytes, is_tag, input ready);
	modport sink (input valid, out_hi, out_lo, out_bytes, is_tag, output ready);
endinterface

// File: rtl/core/aes_gcm_authenticated_cipher.sv
// AES-GCM engine, one 16-byte block per item, 128/192/256-bit keys.
// src takes items (mode, in_hi, in_lo, in_bytes); dst returns results
// (out_hi, out_lo, out_bytes, is_tag). Both use valid/ready.
// Key, key length and direction must be written on cfg_we/cfg_idx/cfg_data
// only while the engine is idle; the block itself does not enforce this.
// Steps per item after the accept, with one AES round per cycle and an
// 8-bit-a-cycle GHASH multiplier, Nr = 10/12/14:
//   start  : 44/52/60 key schedule words, then the AES rounds for H
//   aad    : GHASH
//   text   : AES rounds for the keystream, emit, then GHASH
//   finish : GHASH of lengths, AES rounds on the first counter, emit tag
// Items with a zero byte count on aad or text are accepted and skipped.
// Reset clears all control state, keys, H, tag, counters and counts;
// the round key store is loaded by the next start item.
// A result sits in an output register; if dst stalls, a following
// result waits in its emit step until the register is free.
module aes_gcm_authenticated_cipher
	import gcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	gcm_in_if.sink      src,
	gcm_out_if.source   dst
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_KEY  = 3'd1;
	localparam logic [2:0] S_LD   = 3'd2;
	localparam logic [2:0] S_RND  = 3'd3;
	localparam logic [2:0] S_GH   = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]   state_q;
	logic [1:0]   op_q;
	logic [63:0]  key_q [4];
	logic [1:0]   ksel_q;
	logic         dec_q;
	block_t       blk_q, mask_q, st_q, x_q, v_q, z_q;
	block_t       tag_q, h_q, ctr_q, ctr0_q;
	logic [4:0]   n_q;
	logic [3:0]   rnd_q, gcnt_q;
	logic [63:0]  aadc_q, txtc_q;
	logic [5:0]   ki_q;
	logic [2:0]   kmod_q;
	logic [3:0]   kdiv_q;
	logic [31:0]  win_q [8];
	logic [63:0]  rk_mem [RK_DEPTH];
	logic [63:0]  rka_q, rkb_q;
	logic [63:0]  ovhi_q, ovlo_q;
	logic [4:0]   ovn_q;
	logic         ovtag_q, ov_q;

	logic [1:0]   sel;
	logic [3:0]   nr, nk;
	logic [5:0]   klast;
	logic [31:0]  kw_new, kt, kold;
	logic [3:0]   rd_r;
	logic [4:0]   rd_a, rd_b;
	block_t       st_nx, z_nx, v_nx, res, tagk, inblk, inmask;
	logic [4:0]   in_n;
	logic         emit_ok;

	always_comb begin
		sel   = (ksel_q == 2'd3) ? 2'd2 : ksel_q;
		nr    = 4'd10 + {1'b0, sel, 1'b0};
		nk    = 4'd4 + {1'b0, sel, 1'b0};
		klast = 6'd43 + {1'b0, sel, 3'b000};
		kold  = win_q[3'(nk - 4'd1)];
		kt    = win_q[0];
		if (kmod_q == 3'd0)
			kt = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon(kdiv_q), 24'h0};
		else if (nk == 4'd8 && kmod_q == 3'd4)
			kt = sub_word(win_q[0]);
		if (ki_q < 6'(nk))
			kw_new = ki_q[0] ? key_q[ki_q[2:1]][31:0] : key_q[ki_q[2:1]][63:32];
		else
			kw_new = kold ^ kt;
	end

	// round key read address, next round while running
	always_comb begin
		rd_r = (state_q == S_RND) ? rnd_q + 4'd1 : 4'd0;
		if (rd_r > 4'd14)
			rd_r = 4'd0;
		rd_a = {rd_r, 1'b0};
		rd_b = {rd_r, 1'b1};
	end

	always_ff @(posedge clk) begin
		if (state_q == S_KEY && ki_q[0])
			rk_mem[ki_q[5:1]] <= {win_q[0], kw_new};
		rka_q <= rk_mem[rd_a];
		rkb_q <= rk_mem[rd_b];
	end

	always_comb begin
		if (rnd_q == 4'd0)
			st_nx = st_q ^ {rka_q, rkb_q};
		else
			st_nx = aes_round(st_q, rnd_q == nr) ^ {rka_q, rkb_q};
	end

	// eight GHASH bits per cycle, msb first
	always_comb begin
		z_nx = z_q;
		v_nx = v_q;
		for (int i = 0; i < 8; i++) begin
			if (x_q[127 - i])
				z_nx = z_nx ^ v_nx;
			v_nx = {1'b0, v_nx[127:1]} ^ (v_nx[0] ? {8'he1, 120'h0} : '0);
		end
	end

	always_comb begin
		in_n   = (src.in_bytes > 5'd16) ? 5'd16 : src.in_bytes;
		inmask = byte_mask(in_n);
		inblk  = {src.in_hi, src.in_lo} & inmask;
		res    = (blk_q ^ st_q) & mask_q;
		tagk   = tag_q ^ st_q;
		emit_ok = !ov_q || dst.ready;
	end

	assign src.ready     = (state_q == S_IDLE);
	assign dst.valid     = ov_q;
	assign dst.out_hi    = ovhi_q;
	assign dst.out_lo    = ovlo_q;
	assign dst.out_bytes = ovn_q;
	assign dst.is_tag    = ovtag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= MODE_START;
			for (int k = 0; k < 4; k++)
				key_q[k] <= '0;
			ksel_q  <= '0;
			dec_q   <= 1'b0;
			tag_q   <= '0;
			h_q     <= '0;
			ctr_q   <= '0;
			ctr0_q  <= '0;
			aadc_q  <= '0;
			txtc_q  <= '0;
			rnd_q   <= '0;
			gcnt_q  <= '0;
			ki_q    <= '0;
			kmod_q  <= '0;
			kdiv_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					REG_KEY_LEN: ksel_q <= cfg_data[1:0];
					REG_DECRYPT: dec_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == S_EMIT && emit_ok)
				ov_q <= 1'b1;
			else if (dst.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (src.valid) begin
						op_q <= src.mode;
						unique case (src.mode)
							MODE_START: begin
								ctr0_q  <= {src.in_hi, src.in_lo[63:32], 32'h1};
								ctr_q   <= {src.in_hi, src.in_lo[63:32], 32'h1};
								tag_q   <= '0;
								aadc_q  <= '0;
								txtc_q  <= '0;
								ki_q    <= '0;
								kmod_q  <= '0;
								kdiv_q  <= '0;
								state_q <= S_KEY;
							end
							MODE_AAD: begin
								if (in_n != 5'd0) begin
									aadc_q  <= aadc_q + 64'(in_n);
									x_q     <= tag_q ^ inblk;
									v_q     <= h_q;
									z_q     <= '0;
									gcnt_q  <= '0;
									state_q <= S_GH;
								end
							end
							MODE_TEXT: begin
								if (in_n != 5'd0) begin
									txtc_q  <= txtc_q + 64'(in_n);
									blk_q   <= inblk;
									mask_q  <= inmask;
									n_q     <= in_n;
									ctr_q[31:0] <= ctr_q[31:0] + 32'd1;
									st_q    <= {ctr_q[127:32], ctr_q[31:0] + 32'd1};
									state_q <= S_LD;
								end
							end
							default: begin
								x_q     <= tag_q ^ {aadc_q << 3, txtc_q << 3};
								v_q     <= h_q;
								z_q     <= '0;
								gcnt_q  <= '0;
								state_q <= S_GH;
							end
						endcase
					end
				end
				S_KEY: begin
					win_q[0] <= kw_new;
					for (int k = 1; k < 8; k++)
						win_q[k] <= win_q[k - 1];
					if (kmod_q == 3'(nk - 4'd1)) begin
						kmod_q <= '0;
						kdiv_q <= kdiv_q + 4'd1;
					end else begin
						kmod_q <= kmod_q + 3'd1;
					end
					ki_q <= ki_q + 6'd1;
					if (ki_q == klast) begin
						st_q    <= '0;
						state_q <= S_LD;
					end
				end
				S_LD: begin
					rnd_q   <= '0;
					state_q <= S_RND;
				end
				S_RND: begin
					st_q  <= st_nx;
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == nr) begin
						if (op_q == MODE_START) begin
							h_q     <= st_nx;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_GH: begin
					z_q    <= z_nx;
					v_q    <= v_nx;
					x_q    <= {x_q[119:0], 8'h0};
					gcnt_q <= gcnt_q + 4'd1;
					if (gcnt_q == 4'd15) begin
						tag_q <= z_nx;
						if (op_q == MODE_FINISH) begin
							st_q    <= ctr0_q;
							state_q <= S_LD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (op_q == MODE_FINISH) begin
							ovhi_q  <= tagk[127:64];
							ovlo_q  <= tagk[63:0];
							ovn_q   <= 5'd16;
							ovtag_q <= 1'b1;
							tag_q   <= tagk;
							state_q <= S_IDLE;
						end else begin
							ovhi_q  <= res[127:64];
							ovlo_q  <= res[63:0];
							ovn_q   <= n_q;
							ovtag_q <= 1'b0;
							x_q     <= tag_q ^ (dec_q ? blk_q : res);
							v_q     <= h_q;
							z_q     <= '0;
							gcnt_q  <= '0;
							state_q <= S_GH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: bench/tb_aes_gcm_authenticated_cipher.sv
`timescale 1ns / 1ps

module tb_aes_gcm_authenticated_cipher;
	import gcm_pkg::*;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  nbytes;
	} gcm_item_t;

	typedef struct packed {
		block_t     data;
		logic [4:0] nbytes;
		logic       is_tag;
	} gcm_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [63:0] cfg_data;

	gcm_in_if  src ();
	gcm_out_if dst ();

	aes_gcm_authenticated_cipher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.src(src),
		.dst(dst)
	);

	gcm_item_t   pending_q[$];
	gcm_result_t expected_q[$];
	gcm_item_t   cur_item;
	int          send_gap;
	int          stall_cnt;
	int          mismatches;
	bit          quiet_phase;
	int          items_queued;

	// shadow of the engine state
	logic [63:0] key_w [4];
	logic [1:0]  key_len;
	logic        decrypt_on;
	logic [63:0] rk [30];
	block_t      hkey, tag_acc, ctr, j0;
	logic [63:0] aad_cnt, txt_cnt;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int key_sel();
		return (key_len >= 2) ? 2 : int'(key_len);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] b);
		return (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] w [60];
		logic [7:0]  rc [11];
		logic [31:0] t;
		int nk, total;
		rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
		nk = 4 + 2 * key_sel();
		total = 4 * (11 + 2 * key_sel());
		for (int i = 0; i < nk; i++)
			w[i] = (i % 2) ? key_w[i / 2][31:0] : key_w[i / 2][63:32];
		for (int i = nk; i < total; i++) begin
			t = w[i - 1];
			if (i % nk == 0)
				t = sbox_word({t[23:0], t[31:24]}) ^ {rc[(i / nk) % 11], 24'd0};
			else if (nk > 6 && i % nk == 4)
				t = sbox_word(t);
			w[i] = w[i - nk] ^ t;
		end
		for (int i = 0; i < total; i += 2)
			rk[i / 2] = {w[i], w[i + 1]};
	endfunction

	function automatic block_t aes_encrypt_block(input block_t pt);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		block_t st;
		int nr;
		nr = 10 + 2 * key_sel();
		st = pt ^ {rk[0], rk[1]};
		for (int r = 1; r <= nr; r++) begin
			for (int j = 0; j < 16; j++)
				s[j] = SBOX[st[127 - 8 * j -: 8]];
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					t[c * 4 + j] = s[((c + j) % 4) * 4 + j];
			if (r != nr) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[c * 4];
					a1 = t[c * 4 + 1];
					a2 = t[c * 4 + 2];
					a3 = t[c * 4 + 3];
					al = a0 ^ a1 ^ a2 ^ a3;
					t[c * 4]     = a0 ^ al ^ dbl(a0 ^ a1);
					t[c * 4 + 1] = a1 ^ al ^ dbl(a1 ^ a2);
					t[c * 4 + 2] = a2 ^ al ^ dbl(a2 ^ a3);
					t[c * 4 + 3] = a3 ^ al ^ dbl(a3 ^ a0);
				end
			end
			for (int j = 0; j < 16; j++)
				st[127 - 8 * j -: 8] = t[j];
			st ^= {rk[(2 * r) % 30], rk[(2 * r + 1) % 30]};
		end
		return st;
	endfunction

	function automatic block_t gf_mul(input block_t x, input block_t h);
		block_t z, v;
		logic   lsb;
		z = '0;
		v = h;
		for (int i = 0; i < 128; i++) begin
			lsb = v[0];
			if (x[127 - i])
				z ^= v;
			v = v >> 1;
			if (lsb)
				v[127:120] ^= 8'he1;
		end
		return z;
	endfunction

	function automatic block_t lead_mask(input int n);
		block_t ones;
		ones = '1;
		if (n >= 16)
			return ones;
		return ones << (8 * (16 - n));
	endfunction

	function automatic void predict_item(input gcm_item_t it);
		int     n;
		block_t m, blk, ks, res;
		n = (it.nbytes > 16) ? 16 : int'(it.nbytes);
		case (it.mode)
			MODE_START: begin
				expand_round_keys();
				hkey = aes_encrypt_block('0);
				tag_acc = '0;
				j0 = {it.hi, it.lo[63:32], 32'd1};
				ctr = j0;
				aad_cnt = '0;
				txt_cnt = '0;
			end
			MODE_FINISH: begin
				tag_acc = gf_mul(tag_acc ^ {aad_cnt << 3, txt_cnt << 3}, hkey);
				tag_acc ^= aes_encrypt_block(j0);
				expected_q.push_back('{tag_acc, 5'd16, 1'b1});
			end
			default: begin
				if (n != 0) begin
					m = lead_mask(n);
					blk = {it.hi, it.lo} & m;
					if (it.mode == MODE_AAD) begin
						aad_cnt += 64'(n);
						tag_acc = gf_mul(tag_acc ^ blk, hkey);
					end else begin
						txt_cnt += 64'(n);
						ctr[31:0] = ctr[31:0] + 32'd1;
						ks = aes_encrypt_block(ctr);
						res = (blk ^ ks) & m;
						tag_acc = gf_mul(tag_acc ^ (decrypt_on ? blk : res), hkey);
						expected_q.push_back('{res, 5'(n), 1'b0});
					end
				end
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src.valid <= 1'b0;
			src.mode <= MODE_START;
			src.in_hi <= '0;
			src.in_lo <= '0;
			src.in_bytes <= '0;
			send_gap = 0;
		end else begin
			if (src.valid && src.ready)
				predict_item(cur_item);
			if (src.valid && !src.ready) begin
			end else if (send_gap > 0) begin
				send_gap--;
				src.valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				cur_item = pending_q.pop_front();
				src.mode <= cur_item.mode;
				src.in_hi <= cur_item.hi;
				src.in_lo <= cur_item.lo;
				src.in_bytes <= cur_item.nbytes;
				src.valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				src.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		gcm_result_t want;
		if (!arst_n) begin
			dst.ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (dst.valid && dst.ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h %h bytes %0d tag %b",
							dst.out_hi, dst.out_lo, dst.out_bytes, dst.is_tag);
				end else begin
					want = expected_q.pop_front();
					if ({dst.out_hi, dst.out_lo} !== want.data || dst.out_bytes !== want.nbytes
							|| dst.is_tag !== want.is_tag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h bytes %0d tag %b, got %h%h bytes %0d tag %b",
								want.data, want.nbytes, want.is_tag,
								dst.out_hi, dst.out_lo, dst.out_bytes, dst.is_tag);
					end
				end
			end
			if (stall_cnt > 0)
				stall_cnt--;
			else
				stall_cnt = pick_gap();
			dst.ready <= (stall_cnt == 0);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_KEY_LEN: key_len = val[1:0];
			REG_DECRYPT: decrypt_on = val[0];
			default: key_w[idx[1:0]] = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] k0, k1, k2, k3, input logic [1:0] kl,
			input logic dec);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_KEY_LEN, 64'(kl));
		write_reg(REG_DECRYPT, 64'(dec));
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || src.valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic push_item(input logic [1:0] md, input logic [63:0] hi, lo,
			input logic [4:0] nb);
		pending_q.push_back('{md, hi, lo, nb});
		items_queued++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [4:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 5'd16;
		if (r < 85)
			return 5'($urandom_range(1, 15));
		if (r < 92)
			return 5'd0;
		return 5'($urandom_range(17, 31));
	endfunction

	initial begin
		logic [1:0] md;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_KEY0;
		cfg_data = '0;
		quiet_phase = 1'b0;
		mismatches = 0;
		items_queued = 0;
		key_w = '{default: '0};
		key_len = '0;
		decrypt_on = 1'b0;
		rk = '{default: '0};
		hkey = '0;
		tag_acc = '0;
		ctr = '0;
		j0 = '0;
		aad_cnt = '0;
		txt_cnt = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// 128-bit key of all ones, encrypt, field extremes
		set_config('1, '1, '1, '1, 2'd0, 1'b0);
		push_item(MODE_START, '1, '1, 5'd31);
		push_item(MODE_AAD, '1, '1, 5'd16);
		push_item(MODE_AAD, '1, '1, 5'd0);
		push_item(MODE_AAD, 64'h0123456789abcdef, '1, 5'd5);
		push_item(MODE_TEXT, '0, '0, 5'd16);
		push_item(MODE_TEXT, '1, '1, 5'd8);
		push_item(MODE_TEXT, '1, '1, 5'd1);
		push_item(MODE_TEXT, '1, '1, 5'd0);
		push_item(MODE_TEXT, '1, '1, 5'd20);
		push_item(MODE_FINISH, '0, '0, 5'd0);
		push_item(MODE_FINISH, '1, '1, 5'd31);
		wait_idle();

		// 256-bit key, decrypt, zero iv
		set_config(rand64(), rand64(), rand64(), rand64(), 2'd2, 1'b1);
		push_item(MODE_START, '0, '0, 5'd0);
		push_item(MODE_AAD, rand64(), rand64(), 5'd12);
		push_item(MODE_TEXT, rand64(), rand64(), 5'd16);
		push_item(MODE_TEXT, rand64(), rand64(), 5'd9);
		wait_idle();

		// key length changed mid-message
		write_reg(REG_KEY_LEN, 64'd0);
		push_item(MODE_TEXT, rand64(), rand64(), 5'd16);
		push_item(MODE_FINISH, '0, '0, 5'd0);
		wait_idle();

		// 192-bit key, then select three
		set_config(rand64(), rand64(), rand64(), '0, 2'd1, 1'b0);
		push_item(MODE_START, rand64(), rand64(), 5'd16);
		push_item(MODE_TEXT, rand64(), rand64(), 5'd16);
		push_item(MODE_FINISH, '0, '0, 5'd0);
		wait_idle();
		write_reg(REG_KEY_LEN, 64'd3);
		push_item(MODE_START, rand64(), rand64(), 5'd16);
		push_item(MODE_AAD, rand64(), rand64(), 5'd16);
		push_item(MODE_TEXT, rand64(), rand64(), 5'd16);
		push_item(MODE_FINISH, '0, '0, 5'd0);
		wait_idle();

		while (items_queued < 900) begin
			quiet_phase = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_KEY_LEN, 64'($urandom_range(0, 3)));
			else
				set_config(rand64(), rand64(), rand64(), rand64(),
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 7) != 0)
					push_item(MODE_START, rand64(), rand64(), 5'($urandom()));
				repeat ($urandom_range(0, 3))
					push_item(MODE_AAD, rand64(), rand64(), rand_count());
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 9) == 0) begin
						md = 2'($urandom_range(1, 3));
						push_item(md, rand64(), rand64(), 5'($urandom()));
					end else begin
						push_item(MODE_TEXT, rand64(), rand64(), rand_count());
					end
				end
				push_item(MODE_FINISH, rand64(), rand64(), 5'($urandom()));
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
